[hdl/ria_pkg.sv]
// ----------------------------------------------------------------------------
// ria_pkg
// Shared widths, operation codes and controller states of the reference
// counted identifier allocator.
// ----------------------------------------------------------------------------
package ria_pkg;

  localparam int MODE_W  = 2;
  localparam int ID_W    = 9;
  localparam int OWNER_W = 16;
  localparam int COUNT_W = 16;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GET   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

[hdl/ria_if.sv]
// ----------------------------------------------------------------------------
// ria_if
// Request and response channels of the identifier allocator, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface ria_req_if;
  logic                        valid;
  logic                        ready;
  logic [ria_pkg::MODE_W-1:0]  mode;
  logic [ria_pkg::ID_W-1:0]    id_in;
  logic [ria_pkg::OWNER_W-1:0] owner_in;

  modport source (output valid, mode, id_in, owner_in, input ready);
  modport sink (input valid, mode, id_in, owner_in, output ready);
endinterface

interface ria_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ria_pkg::ID_W-1:0]    id_out;
  logic [ria_pkg::OWNER_W-1:0] owner_out;
  logic                        ok;
  logic                        released;
  logic [ria_pkg::COUNT_W-1:0] count_out;

  modport source (output valid, id_out, owner_out, ok, released, count_out, input ready);
  modport sink (input valid, id_out, owner_out, ok, released, count_out, output ready);
endinterface

[hdl/ria_bitmap.sv]
// ----------------------------------------------------------------------------
// ria_bitmap
// Word-organized used map with a registered read, a clearing pass after reset
// that marks the reserved ids, and a lowest-free-bit search over the word just
// read, masked by scan_lo on the first and last word of a scan.
// ----------------------------------------------------------------------------
module ria_bitmap #(
  parameter int ID_BITS  = 9,
  parameter int RESERVED = 4
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic [ID_BITS-((ID_BITS > 5) ? 5 : ID_BITS-1)-1:0] rd_word,
  input  logic                                     wr_en,
  input  logic [ID_BITS-((ID_BITS > 5) ? 5 : ID_BITS-1)-1:0] wr_word,
  input  logic [(1 << ((ID_BITS > 5) ? 5 : ID_BITS-1))-1:0]  wr_bits,
  input  logic [((ID_BITS > 5) ? 5 : ID_BITS-1)-1:0]         scan_lo,
  input  logic                                     scan_first,
  input  logic                                     scan_last,
  output logic [(1 << ((ID_BITS > 5) ? 5 : ID_BITS-1))-1:0]  rd_bits,
  output logic                                     free_found,
  output logic [((ID_BITS > 5) ? 5 : ID_BITS-1)-1:0]         free_bit,
  output logic                                     busy
);

  localparam int LW     = (ID_BITS > 5) ? 5 : ID_BITS - 1;
  localparam int W      = 1 << LW;
  localparam int WB     = ID_BITS - LW;
  localparam int NWORDS = 1 << WB;

  logic [W-1:0]  map_mem [NWORDS];
  logic [W-1:0]  rd_bits_r;
  logic [WB-1:0] clr_word_r;
  logic [WB-1:0] clr_word_nxt;
  logic          busy_r;
  logic          busy_nxt;
  logic [W-1:0]  rsv_bits;
  logic [W-1:0]  scan_mask;
  logic [W-1:0]  free_bits;
  logic          mem_we;
  logic [WB-1:0] mem_waddr;
  logic [W-1:0]  mem_wdata;

  always_comb begin
    for (int j = 0; j < W; j++) begin
      rsv_bits[j] = ({clr_word_r, LW'(j)} < RESERVED);
    end
  end

  always_comb begin
    clr_word_nxt = clr_word_r + 1'b1;
    busy_nxt     = busy_r && (clr_word_r != {WB{1'b1}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_word_r <= '0;
      busy_r     <= 1'b1;
    end else begin
      if (busy_r) begin
        clr_word_r <= clr_word_nxt;
      end
      busy_r <= busy_nxt;
    end
  end

  always_comb begin
    mem_we    = busy_r || wr_en;
    mem_waddr = busy_r ? clr_word_r : wr_word;
    mem_wdata = busy_r ? rsv_bits : wr_bits;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rd_bits_r <= map_mem[rd_word];
  end

  always_comb begin
    for (int j = 0; j < W; j++) begin
      if (scan_first) begin
        scan_mask[j] = (LW'(j) >= scan_lo);
      end else if (scan_last) begin
        scan_mask[j] = (LW'(j) < scan_lo);
      end else begin
        scan_mask[j] = 1'b1;
      end
    end
    free_bits = ~rd_bits_r & scan_mask;
  end

  always_comb begin
    free_bit = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        free_bit = LW'(j);
      end
    end
  end

  assign free_found = |free_bits;
  assign rd_bits    = rd_bits_r;
  assign busy       = busy_r;

endmodule

[hdl/ria_entry_store.sv]
// ----------------------------------------------------------------------------
// ria_entry_store
// Per-id reference count and owner handle memory with a registered read, and
// the saturating count update for get and put.
// ----------------------------------------------------------------------------
module ria_entry_store #(
  parameter int ID_BITS    = 9,
  parameter int COUNT_BITS = 16,
  parameter int OWNER_BITS = 16
) (
  input  logic                  clk,
  input  logic [ID_BITS-1:0]    rd_addr,
  input  logic                  wr_en,
  input  logic [ID_BITS-1:0]    wr_addr,
  input  logic [COUNT_BITS-1:0] wr_count,
  input  logic [OWNER_BITS-1:0] wr_owner,
  input  logic                  incr,
  output logic [COUNT_BITS-1:0] rd_count,
  output logic [OWNER_BITS-1:0] rd_owner,
  output logic [COUNT_BITS-1:0] upd_count
);

  localparam int NUM_IDS = 1 << ID_BITS;

  logic [COUNT_BITS+OWNER_BITS-1:0] ent_mem [NUM_IDS];
  logic [COUNT_BITS+OWNER_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_mem[wr_addr] <= {wr_count, wr_owner};
    end
    rd_data_r <= ent_mem[rd_addr];
  end

  assign rd_count = rd_data_r[COUNT_BITS+OWNER_BITS-1:OWNER_BITS];
  assign rd_owner = rd_data_r[OWNER_BITS-1:0];

  always_comb begin
    if (incr) begin
      upd_count = (rd_count == {COUNT_BITS{1'b1}}) ? rd_count : rd_count + 1'b1;
    end else begin
      upd_count = (rd_count == '0) ? rd_count : rd_count - 1'b1;
    end
  end

endmodule

[hdl/refcounted_id_allocator_core.sv]
// ----------------------------------------------------------------------------
// refcounted_id_allocator_core
// Reference-counted identifier allocator built around a used-map memory and
// a count/owner memory.
//
// Requests arrive on in_chan: allocate takes a new id for owner_in, get takes
// a reference on id_in and returns its owner, put drops a reference and frees
// the id when the count reaches zero. Each transaction yields exactly one
// response on out_chan.
// Get and put read both memories, update and write back, then load the output
// register. Allocate scans map words of 2^min(5, ID_BITS-1) ids from the probe
// pointer, at most 2^ID_BITS / word size + 1 of them; the used-map read port
// sets the pace of the scan. After reset a clearing pass writes one map word
// per cycle and marks the reserved ids; in_chan.ready stays low meanwhile.
// The response is held in an output register, so a stalled receiver only
// holds the block once the next response is ready and the register is full.
// ----------------------------------------------------------------------------
module refcounted_id_allocator_core #(
  parameter int ID_BITS    = 9,
  parameter int RESERVED   = 4,
  parameter int COUNT_BITS = 16,
  parameter int OWNER_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ria_req_if.sink    in_chan,
  ria_rsp_if.source  out_chan
);

  localparam int LW     = (ID_BITS > 5) ? 5 : ID_BITS - 1;
  localparam int W      = 1 << LW;
  localparam int WB     = ID_BITS - LW;
  localparam int NWORDS = 1 << WB;
  localparam logic [WB:0] SCAN_LAST = (WB + 1)'(NWORDS);

  ria_pkg::state_t state_r, state_nxt;

  logic [ria_pkg::MODE_W-1:0] mode_r;
  logic [ID_BITS-1:0]         id_r;
  logic [OWNER_BITS-1:0]      owner_r;
  logic [ID_BITS-1:0]         probe_r, probe_nxt;
  logic [WB-1:0]              scan_word_r;
  logic [WB:0]                scan_cnt_r;

  logic [ID_BITS-1:0]    res_id_r, res_id_nxt;
  logic [OWNER_BITS-1:0] res_owner_r, res_owner_nxt;
  logic                  res_ok_r, res_ok_nxt;
  logic                  res_rel_r, res_rel_nxt;
  logic [COUNT_BITS-1:0] res_count_r, res_count_nxt;
  logic                  res_load;
  logic                  probe_load;

  logic                  out_valid_r;
  logic                  out_load;
  logic [ria_pkg::ID_W-1:0]    out_id_r;
  logic [ria_pkg::OWNER_W-1:0] out_owner_r;
  logic                        out_ok_r;
  logic                        out_rel_r;
  logic [ria_pkg::COUNT_W-1:0] out_count_r;

  logic                  accept;
  logic [ID_BITS-1:0]    in_id;
  logic [OWNER_BITS-1:0] in_owner;

  logic [WB-1:0]         map_rd_word;
  logic                  map_we;
  logic [WB-1:0]         map_wr_word;
  logic [W-1:0]          map_wr_bits;
  logic [W-1:0]          map_rd_bits;
  logic                  free_found;
  logic [LW-1:0]         free_bit;
  logic                  map_busy;
  logic                  scan_first;
  logic                  scan_last;

  logic                  ent_we;
  logic [ID_BITS-1:0]    ent_rd_addr;
  logic [ID_BITS-1:0]    ent_wr_addr;
  logic [COUNT_BITS-1:0] ent_wr_count;
  logic [OWNER_BITS-1:0] ent_wr_owner;
  logic [COUNT_BITS-1:0] ent_rd_count;
  logic [OWNER_BITS-1:0] ent_rd_owner;
  logic [COUNT_BITS-1:0] ent_upd_count;

  logic                  id_live;
  logic [W-1:0]          id_onehot;
  logic [ID_BITS-1:0]    cand;

  assign in_id    = ID_BITS'(in_chan.id_in);
  assign in_owner = OWNER_BITS'(in_chan.owner_in);
  assign accept   = in_chan.valid && in_chan.ready;

  assign scan_first = (scan_cnt_r == '0);
  assign scan_last  = (scan_cnt_r == SCAN_LAST);
  assign id_onehot  = W'(1) << id_r[LW-1:0];
  assign id_live    = map_rd_bits[id_r[LW-1:0]] && (id_r >= RESERVED);
  assign cand       = {scan_word_r, free_bit};

  ria_bitmap #(
    .ID_BITS  (ID_BITS),
    .RESERVED (RESERVED)
  ) u_bitmap (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_word    (map_rd_word),
    .wr_en      (map_we),
    .wr_word    (map_wr_word),
    .wr_bits    (map_wr_bits),
    .scan_lo    (probe_r[LW-1:0]),
    .scan_first (scan_first),
    .scan_last  (scan_last),
    .rd_bits    (map_rd_bits),
    .free_found (free_found),
    .free_bit   (free_bit),
    .busy       (map_busy)
  );

  ria_entry_store #(
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS),
    .OWNER_BITS (OWNER_BITS)
  ) u_entry_store (
    .clk       (clk),
    .rd_addr   (ent_rd_addr),
    .wr_en     (ent_we),
    .wr_addr   (ent_wr_addr),
    .wr_count  (ent_wr_count),
    .wr_owner  (ent_wr_owner),
    .incr      (mode_r == ria_pkg::MODE_GET),
    .rd_count  (ent_rd_count),
    .rd_owner  (ent_rd_owner),
    .upd_count (ent_upd_count)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ria_pkg::ST_CLEAR: begin
        if (!map_busy) begin
          state_nxt = ria_pkg::ST_IDLE;
        end
      end
      ria_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = (in_chan.mode == ria_pkg::MODE_ALLOC) ? ria_pkg::ST_SCAN
                                                            : ria_pkg::ST_LOOK;
        end
      end
      ria_pkg::ST_LOOK: begin
        state_nxt = ria_pkg::ST_DONE;
      end
      ria_pkg::ST_SCAN: begin
        if (free_found || scan_last) begin
          state_nxt = ria_pkg::ST_DONE;
        end
      end
      ria_pkg::ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = ria_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ria_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_chan.ready = (state_r == ria_pkg::ST_IDLE);
    out_load      = (state_r == ria_pkg::ST_DONE) && (!out_valid_r || out_chan.ready);

    if (state_r == ria_pkg::ST_IDLE) begin
      map_rd_word = (in_chan.mode == ria_pkg::MODE_ALLOC) ? probe_r[ID_BITS-1:LW]
                                                          : in_id[ID_BITS-1:LW];
    end else begin
      map_rd_word = scan_word_r + 1'b1;
    end
    ent_rd_addr = (state_r == ria_pkg::ST_IDLE) ? in_id : id_r;

    map_we        = 1'b0;
    map_wr_word   = id_r[ID_BITS-1:LW];
    map_wr_bits   = map_rd_bits & ~id_onehot;
    ent_we        = 1'b0;
    ent_wr_addr   = id_r;
    ent_wr_count  = ent_upd_count;
    ent_wr_owner  = ent_rd_owner;
    res_load      = 1'b0;
    probe_load    = 1'b0;
    probe_nxt     = cand + 1'b1;
    res_id_nxt    = id_r;
    res_owner_nxt = '0;
    res_ok_nxt    = 1'b0;
    res_rel_nxt   = 1'b0;
    res_count_nxt = '0;

    unique case (state_r)
      ria_pkg::ST_LOOK: begin
        res_load = 1'b1;
        if (id_live && (mode_r == ria_pkg::MODE_GET || mode_r == ria_pkg::MODE_PUT)) begin
          ent_we        = 1'b1;
          res_owner_nxt = ent_rd_owner;
          res_ok_nxt    = 1'b1;
          if (mode_r == ria_pkg::MODE_PUT && ent_upd_count == '0) begin
            map_we      = 1'b1;
            res_rel_nxt = 1'b1;
          end else begin
            res_count_nxt = ent_upd_count;
          end
        end
      end
      ria_pkg::ST_SCAN: begin
        map_wr_word  = scan_word_r;
        map_wr_bits  = map_rd_bits | (W'(1) << free_bit);
        ent_wr_addr  = cand;
        ent_wr_count = COUNT_BITS'(1);
        ent_wr_owner = owner_r;
        res_id_nxt   = '0;
        if (free_found) begin
          map_we        = 1'b1;
          ent_we        = 1'b1;
          res_load      = 1'b1;
          probe_load    = 1'b1;
          res_id_nxt    = cand;
          res_owner_nxt = owner_r;
          res_ok_nxt    = 1'b1;
          res_count_nxt = COUNT_BITS'(1);
        end else if (scan_last) begin
          res_load = 1'b1;
        end
      end
      ria_pkg::ST_CLEAR, ria_pkg::ST_IDLE, ria_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ria_pkg::ST_CLEAR;
      probe_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (probe_load) begin
        probe_r <= probe_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r      <= in_chan.mode;
      id_r        <= in_id;
      owner_r     <= in_owner;
      scan_word_r <= probe_r[ID_BITS-1:LW];
      scan_cnt_r  <= '0;
    end else if (state_r == ria_pkg::ST_SCAN) begin
      scan_word_r <= scan_word_r + 1'b1;
      scan_cnt_r  <= scan_cnt_r + 1'b1;
    end
    if (res_load) begin
      res_id_r    <= res_id_nxt;
      res_owner_r <= res_owner_nxt;
      res_ok_r    <= res_ok_nxt;
      res_rel_r   <= res_rel_nxt;
      res_count_r <= res_count_nxt;
    end
    if (out_load) begin
      out_id_r    <= ria_pkg::ID_W'(res_id_r);
      out_owner_r <= ria_pkg::OWNER_W'(res_owner_r);
      out_ok_r    <= res_ok_r;
      out_rel_r   <= res_rel_r;
      out_count_r <= ria_pkg::COUNT_W'(res_count_r);
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.id_out    = out_id_r;
  assign out_chan.owner_out = out_owner_r;
  assign out_chan.ok        = out_ok_r;
  assign out_chan.released  = out_rel_r;
  assign out_chan.count_out = out_count_r;

endmodule
